FILE: rtl/bsl_pkg.sv
// ----------------------------------------------------------------------------
// bsl_pkg : shared definitions for the bounded sequence list
// Command and status codes, field widths and default sizes.
// ----------------------------------------------------------------------------
package bsl_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // field widths fixed by the stream format
    localparam int CMD_W    = 2;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 4;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    localparam logic [CMD_W-1:0] CMD_INS_FRONT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INS_REAR  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FIND      = 2'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;

endpackage

FILE: rtl/bsl_ram.sv
// ----------------------------------------------------------------------------
// bsl_ram : simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bsl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/bounded_sequence_list.sv
// ----------------------------------------------------------------------------
// bounded_sequence_list : ordered list with insert, find and remove
// Holds up to DEPTH values in positions 0 .. count-1 in a RAM and walks it
// with one read port and one write port under a small sequencer.
// ----------------------------------------------------------------------------
//
//  channel | dir | ports                         | content
//  --------+-----+-------------------------------+-----------------------------
//  s_      | in  | s_tvalid s_tready s_tdata     | command beat: cmd in tuser,
//          |     | s_tuser                       | value and index in tdata
//  m_      | out | m_tvalid m_tready m_tdata     | result beat: status in tuser,
//          |     | m_tuser                       | position, removed value, count
//
//  Insert rear, a full list and an early miss go straight to the emit stage;
//  insert front walks the whole list, find walks up to the first hit, and
//  remove walks from the index to the end. The single RAM port pair sets the
//  pace: every shift or compare moves one entry per cycle.
//  aresetn (synchronous, active low) clears the count and the sequencer; the
//  RAM is not cleared, since only positions below the count are ever read.
//  A result beat waits in the output register while the next command runs;
//  the sequencer holds in its emit stage only if that register is still full.
//
module bounded_sequence_list #(
    parameter int DEPTH      = bsl_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = bsl_pkg::DATA_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [31:0] value, [35:32] index, [39:36] zero
    input  logic [bsl_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] cmd
    input  logic [bsl_pkg::CMD_W-1:0]      s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [3:0] position, [35:4] removed_value, [40:36] count, [47:41] zero
    output logic [bsl_pkg::M_TDATA_W-1:0]  m_tdata,
    // [1:0] status
    output logic [bsl_pkg::STATUS_W-1:0]   m_tuser
);

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int VW  = (DATA_WIDTH < bsl_pkg::VALUE_W) ? DATA_WIDTH : bsl_pkg::VALUE_W;
    localparam int PW  = (AW < bsl_pkg::POS_W) ? AW : bsl_pkg::POS_W;
    localparam int CO  = (CW < bsl_pkg::COUNT_W) ? CW : bsl_pkg::COUNT_W;
    localparam int IXW = (CW > bsl_pkg::INDEX_W) ? CW : bsl_pkg::INDEX_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SHUP = 3'd1;
    localparam logic [2:0] S_FIND = 3'd2;
    localparam logic [2:0] S_RMV  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    // control state
    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          issue_reg, issue_next;   // a RAM read is still to be issued
    logic          pend_reg, pend_next;     // read data for paddr arrives now
    logic          m_valid_reg, m_valid_next;

    // working payload
    logic [AW-1:0]                  ptr_reg, ptr_next;
    logic [AW-1:0]                  paddr_reg, paddr_next;
    logic [DATA_WIDTH-1:0]          val_reg, val_next;
    logic [bsl_pkg::INDEX_W-1:0]    idx_reg, idx_next;
    logic [bsl_pkg::STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [bsl_pkg::POS_W-1:0]      res_pos_reg, res_pos_next;
    logic [bsl_pkg::VALUE_W-1:0]    res_rem_reg, res_rem_next;

    // output beat
    logic [bsl_pkg::STATUS_W-1:0]   m_status_reg, m_status_next;
    logic [bsl_pkg::POS_W-1:0]      m_pos_reg, m_pos_next;
    logic [bsl_pkg::VALUE_W-1:0]    m_rem_reg, m_rem_next;
    logic [bsl_pkg::COUNT_W-1:0]    m_count_reg, m_count_next;

    // RAM port
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic [DATA_WIDTH-1:0]       val_in;
    logic [bsl_pkg::INDEX_W-1:0] idx_in;
    logic [AW-1:0]               last_addr;
    logic                        full;

    bsl_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // keep only the low DATA_WIDTH bits of the incoming value
    assign val_in    = DATA_WIDTH'(s_tdata[VW-1:0]);
    assign idx_in    = s_tdata[bsl_pkg::VALUE_W +: bsl_pkg::INDEX_W];
    assign last_addr = AW'(count_reg - 1'b1);
    assign full      = (count_reg == CW'(DEPTH));

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {7'd0, m_count_reg, m_rem_reg, m_pos_reg};

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        issue_next      = issue_reg;
        pend_next       = pend_reg;
        m_valid_next    = m_valid_reg;
        ptr_next        = ptr_reg;
        paddr_next      = paddr_reg;
        val_next        = val_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        res_rem_next    = res_rem_reg;
        m_status_next   = m_status_reg;
        m_pos_next      = m_pos_reg;
        m_rem_next      = m_rem_reg;
        m_count_next    = m_count_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = ram_rdata;
        ram_raddr       = ptr_reg;

        // drop the output beat once taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    val_next        = val_in;
                    idx_next        = idx_in;
                    res_status_next = bsl_pkg::ST_OK;
                    res_pos_next    = '0;
                    res_rem_next    = '0;
                    pend_next       = 1'b0;
                    case (s_tuser)
                        bsl_pkg::CMD_INS_FRONT: begin
                            if (full) begin
                                res_status_next = bsl_pkg::ST_FULL;
                                state_next      = S_EMIT;
                            end else if (count_reg == '0) begin
                                ram_we     = 1'b1;
                                ram_waddr  = '0;
                                ram_wdata  = val_in;
                                count_next = count_reg + 1'b1;
                                state_next = S_EMIT;
                            end else begin
                                // walk from the top entry down, moving each up one
                                ptr_next   = last_addr;
                                issue_next = 1'b1;
                                state_next = S_SHUP;
                            end
                        end
                        bsl_pkg::CMD_INS_REAR: begin
                            if (full) begin
                                res_status_next = bsl_pkg::ST_FULL;
                            end else begin
                                ram_we     = 1'b1;
                                ram_waddr  = AW'(count_reg);
                                ram_wdata  = val_in;
                                count_next = count_reg + 1'b1;
                            end
                            state_next = S_EMIT;
                        end
                        bsl_pkg::CMD_FIND: begin
                            if (count_reg == '0) begin
                                res_status_next = bsl_pkg::ST_MISS;
                                state_next      = S_EMIT;
                            end else begin
                                ptr_next   = '0;
                                issue_next = 1'b1;
                                state_next = S_FIND;
                            end
                        end
                        bsl_pkg::CMD_REMOVE: begin
                            if (IXW'(idx_in) >= IXW'(count_reg)) begin
                                res_status_next = bsl_pkg::ST_MISS;
                                state_next      = S_EMIT;
                            end else begin
                                // first read fetches the victim, the rest shift down
                                ptr_next   = AW'(idx_in);
                                issue_next = 1'b1;
                                state_next = S_RMV;
                            end
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_SHUP: begin
                if (pend_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(paddr_reg + 1'b1);
                end
                if (issue_reg) begin
                    pend_next  = 1'b1;
                    paddr_next = ptr_reg;
                    if (ptr_reg == '0) begin
                        issue_next = 1'b0;
                    end else begin
                        ptr_next = ptr_reg - 1'b1;
                    end
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        // gap is open at position 0
                        ram_we     = 1'b1;
                        ram_waddr  = '0;
                        ram_wdata  = val_reg;
                        count_next = count_reg + 1'b1;
                        state_next = S_EMIT;
                    end
                end
            end

            S_FIND: begin
                if (issue_reg) begin
                    pend_next  = 1'b1;
                    paddr_next = ptr_reg;
                    if (ptr_reg == last_addr) begin
                        issue_next = 1'b0;
                    end else begin
                        ptr_next = ptr_reg + 1'b1;
                    end
                end else begin
                    pend_next = 1'b0;
                end
                if (pend_reg) begin
                    if (ram_rdata == val_reg) begin
                        res_pos_next = bsl_pkg::POS_W'(paddr_reg[PW-1:0]);
                        issue_next   = 1'b0;
                        pend_next    = 1'b0;
                        state_next   = S_EMIT;
                    end else if (paddr_reg == last_addr) begin
                        res_status_next = bsl_pkg::ST_MISS;
                        pend_next       = 1'b0;
                        state_next      = S_EMIT;
                    end
                end
            end

            S_RMV: begin
                if (pend_reg) begin
                    if (paddr_reg == AW'(idx_reg)) begin
                        res_rem_next = bsl_pkg::VALUE_W'(ram_rdata[VW-1:0]);
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = paddr_reg - 1'b1;
                    end
                end
                if (issue_reg) begin
                    pend_next  = 1'b1;
                    paddr_next = ptr_reg;
                    if (ptr_reg == last_addr) begin
                        issue_next = 1'b0;
                    end else begin
                        ptr_next = ptr_reg + 1'b1;
                    end
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        count_next = count_reg - 1'b1;
                        state_next = S_EMIT;
                    end
                end
            end

            S_EMIT: begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_pos_next    = res_pos_reg;
                    m_rem_next    = res_rem_reg;
                    m_count_next  = bsl_pkg::COUNT_W'(count_reg[CO-1:0]);
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            issue_reg   <= 1'b0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            issue_reg   <= issue_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg        <= ptr_next;
        paddr_reg      <= paddr_next;
        val_reg        <= val_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        res_rem_reg    <= res_rem_next;
        m_status_reg   <= m_status_next;
        m_pos_reg      <= m_pos_next;
        m_rem_reg      <= m_rem_next;
        m_count_reg    <= m_count_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_no_walk_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE || state_reg == S_EMIT) |-> (!issue_reg && !pend_reg))
        else $error("RAM walk still active outside a busy state");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("command accepted while previous one still running");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + 1'b1 || count_reg == $past(count_reg) - 1'b1))
        else $error("entry count moved by more than one");
`endif

endmodule

FILE: tb/sv/bsl_result_checker.sv
// ----------------------------------------------------------------------------
// bsl_result_checker : result prediction and comparison for the sequence list
// Watches both stream channels, keeps its own copy of the list, works out the
// result of every accepted command beat and compares each result beat, field
// by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module bsl_result_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    // [31:0] value, [35:32] index, [39:36] zero
    input  logic [bsl_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] cmd
    input  logic [bsl_pkg::CMD_W-1:0]      s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // [3:0] position, [35:4] removed_value, [40:36] count, [47:41] zero
    input  logic [bsl_pkg::M_TDATA_W-1:0]  m_tdata,
    // [1:0] status
    input  logic [bsl_pkg::STATUS_W-1:0]   m_tuser,
    output int                             fail_count,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [bsl_pkg::STATUS_W-1:0] status;
        logic [bsl_pkg::POS_W-1:0]    position;
        logic [bsl_pkg::VALUE_W-1:0]  removed_value;
        logic [bsl_pkg::COUNT_W-1:0]  count;
    } list_result_t;

    logic [bsl_pkg::VALUE_W-1:0] stored_values [$];
    list_result_t                awaited_results [$];

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    // Apply one command to the shadow list and return the result it yields.
    function automatic list_result_t apply_list_command(
        logic [bsl_pkg::CMD_W-1:0]   cmd,
        logic [bsl_pkg::VALUE_W-1:0] value,
        logic [bsl_pkg::INDEX_W-1:0] index
    );
        list_result_t r;
        int           hit;
        r   = '0;
        hit = -1;
        r.status = bsl_pkg::ST_OK;
        case (cmd)
            bsl_pkg::CMD_INS_FRONT, bsl_pkg::CMD_INS_REAR: begin
                if (stored_values.size() >= bsl_pkg::DEPTH_DEF) begin
                    r.status = bsl_pkg::ST_FULL;
                end else if (cmd == bsl_pkg::CMD_INS_FRONT) begin
                    stored_values.push_front(value);
                end else begin
                    stored_values.push_back(value);
                end
            end
            bsl_pkg::CMD_FIND: begin
                foreach (stored_values[i])
                    if (hit < 0 && stored_values[i] == value)
                        hit = i;
                if (hit < 0) begin
                    r.status = bsl_pkg::ST_MISS;
                end else begin
                    r.position = hit[bsl_pkg::POS_W-1:0];
                end
            end
            default: begin
                if (index >= stored_values.size()) begin
                    r.status = bsl_pkg::ST_MISS;
                end else begin
                    r.removed_value = stored_values[index];
                    stored_values.delete(index);
                end
            end
        endcase
        r.count = bsl_pkg::COUNT_W'(stored_values.size());
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
        $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        list_result_t want;
        if (!aresetn) begin
            stored_values.delete();
            awaited_results.delete();
        end else begin
            if (s_tvalid && s_tready)
                awaited_results.push_back(apply_list_command(s_tuser,
                    s_tdata[bsl_pkg::VALUE_W-1:0],
                    s_tdata[bsl_pkg::VALUE_W +: bsl_pkg::INDEX_W]));
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("result beat with nothing outstanding", m_tdata, '0);
                end else begin
                    want = awaited_results.pop_front();
                    if (m_tuser !== want.status)
                        report_mismatch("status", 48'(m_tuser), 48'(want.status));
                    if (m_tdata[3:0] !== want.position)
                        report_mismatch("position", 48'(m_tdata[3:0]),
                                        48'(want.position));
                    if (m_tdata[35:4] !== want.removed_value)
                        report_mismatch("removed value", 48'(m_tdata[35:4]),
                                        48'(want.removed_value));
                    if (m_tdata[40:36] !== want.count)
                        report_mismatch("count", 48'(m_tdata[40:36]), 48'(want.count));
                    if (m_tdata[47:41] !== '0)
                        report_mismatch("tdata padding", 48'(m_tdata[47:41]), '0);
                end
            end
        end
        pending <= int'(awaited_results.size());
    end

endmodule

FILE: tb/sv/tb_bounded_sequence_list.sv
// ----------------------------------------------------------------------------
// tb_bounded_sequence_list : stream-level test of the bounded sequence list
// Drives command beats with random gaps and result back-pressure, starting
// with a directed pass over the corner cases and then a long random mix of
// fill, drain, balanced and noise phases. A checker beside the block predicts
// and compares every result; this module only makes stimulus and decides.
// ----------------------------------------------------------------------------
module tb_bounded_sequence_list;
    timeunit 1ns;
    timeprecision 1ps;

    // stimulus phases of the random part
    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN, MIX_NOISE} stim_mix_t;

    localparam int RANDOM_BEATS = 1350;
    localparam int PHASE_BEATS  = 50;
    // no idling on either side over the last stretch of the run
    localparam int QUIET_TAIL   = 150;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    // [31:0] value, [35:32] index, [39:36] zero
    logic [bsl_pkg::S_TDATA_W-1:0]  s_tdata;
    // [1:0] cmd
    logic [bsl_pkg::CMD_W-1:0]      s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    // [3:0] position, [35:4] removed_value, [40:36] count, [47:41] zero
    logic [bsl_pkg::M_TDATA_W-1:0]  m_tdata;
    // [1:0] status
    logic [bsl_pkg::STATUS_W-1:0]   m_tuser;

    int  fail_count;
    int  pending;
    bit  idling;
    // rough fill level, kept only to aim removes at live entries
    int  list_fill;
    logic [bsl_pkg::VALUE_W-1:0] value_pool [8];

    bounded_sequence_list dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    bsl_result_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Hard stop: far beyond the slowest legal run (about 2 ms).
    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Present one command beat and hold it until the block takes it. The
    // ready line is sampled mid-cycle, where nothing is changing; the beat
    // then moves at the following rising edge, where the task returns.
    task automatic send_command(
        input logic [bsl_pkg::CMD_W-1:0]   cmd,
        input logic [bsl_pkg::VALUE_W-1:0] value,
        input logic [bsl_pkg::INDEX_W-1:0] index
    );
        if (idling && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, index, value};
        s_tuser  <= cmd;
        forever begin
            @(negedge aclk);
            if (s_tready)
                break;
            @(posedge aclk);
        end
        @(posedge aclk);
        case (cmd)
            bsl_pkg::CMD_INS_FRONT, bsl_pkg::CMD_INS_REAR:
                if (list_fill < bsl_pkg::DEPTH_DEF) list_fill++;
            bsl_pkg::CMD_REMOVE:
                if (index < list_fill) list_fill--;
            default: ;
        endcase
    endtask

    // Mostly draw from a small pool so that finds hit and duplicates occur.
    function automatic logic [bsl_pkg::VALUE_W-1:0] pick_value();
        if ($urandom_range(0, 9) < 7)
            return value_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    // Aim most removes at live entries, the rest anywhere in the index range.
    function automatic logic [bsl_pkg::INDEX_W-1:0] pick_index();
        if (list_fill > 0 && $urandom_range(0, 3) != 0)
            return bsl_pkg::INDEX_W'($urandom_range(0, list_fill - 1));
        return bsl_pkg::INDEX_W'($urandom_range(0, 15));
    endfunction

    // Result side: accept for random stretches, stall in bursts while idling.
    initial begin
        m_tready = 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (idling && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
        end
    end

    initial begin
        stim_mix_t                   mix;
        int                          ins_share;
        int                          find_share;
        int                          roll;
        logic [bsl_pkg::CMD_W-1:0]   cmd;
        logic [bsl_pkg::VALUE_W-1:0] value;
        logic [bsl_pkg::INDEX_W-1:0] index;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = bsl_pkg::CMD_INS_FRONT;
        idling    = 1'b0;
        list_fill = 0;
        mix       = MIX_EVEN;
        ins_share = 0;
        find_share = 0;
        foreach (value_pool[i]) value_pool[i] = '0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // ---- directed part ----
        idling = 1'b1;
        // empty list: remove and find both miss
        send_command(bsl_pkg::CMD_REMOVE, 32'h0000_0000, 4'd0);
        send_command(bsl_pkg::CMD_FIND,   32'h0000_0000, 4'd15);
        // extremes of the value field at both ends; list becomes
        // 0, 80000000, 7fffffff, ffffffff
        send_command(bsl_pkg::CMD_INS_REAR,  32'h7FFF_FFFF, 4'd0);
        send_command(bsl_pkg::CMD_INS_FRONT, 32'h8000_0000, 4'd15);
        send_command(bsl_pkg::CMD_INS_REAR,  32'hFFFF_FFFF, 4'd0);
        send_command(bsl_pkg::CMD_INS_FRONT, 32'h0000_0000, 4'd0);
        send_command(bsl_pkg::CMD_FIND,      32'h7FFF_FFFF, 4'd0);
        // remove well past the count, then exactly at it
        send_command(bsl_pkg::CMD_REMOVE, 32'h0000_0000, 4'd15);
        send_command(bsl_pkg::CMD_REMOVE, 32'h0000_0000, 4'd4);
        // fill up; duplicates go in at the front so find must report the first
        for (int i = 0; i < 11; i++)
            send_command(i[0] ? bsl_pkg::CMD_INS_FRONT : bsl_pkg::CMD_INS_REAR,
                         i[0] ? 32'h7FFF_FFFF : 32'h0100_0000 + i, i[3:0]);
        send_command(bsl_pkg::CMD_INS_REAR, 32'h5A5A_A5A5, 4'd0);
        // full list: both inserts dropped
        send_command(bsl_pkg::CMD_INS_FRONT, 32'h0000_0001, 4'd0);
        send_command(bsl_pkg::CMD_INS_REAR,  32'h0000_0001, 4'd15);
        send_command(bsl_pkg::CMD_FIND, 32'h5A5A_A5A5, 4'd0);
        send_command(bsl_pkg::CMD_FIND, 32'h7FFF_FFFF, 4'd0);
        send_command(bsl_pkg::CMD_FIND, 32'h1234_5678, 4'd0);
        // take the last entry, then the same index is past the count
        send_command(bsl_pkg::CMD_REMOVE, 32'h0000_0000, 4'd15);
        send_command(bsl_pkg::CMD_REMOVE, 32'h0000_0000, 4'd15);
        send_command(bsl_pkg::CMD_REMOVE, 32'h0000_0000, 4'd0);

        // ---- random part ----
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % PHASE_BEATS == 0) begin
                // pick a new phase, refresh the pool, decide on idling
                mix    = stim_mix_t'($urandom_range(0, 3));
                idling = (n < RANDOM_BEATS - QUIET_TAIL) && ($urandom_range(0, 2) != 0);
                foreach (value_pool[i]) value_pool[i] = $urandom;
                if ($urandom_range(0, 1) == 0) begin
                    value_pool[0] = 32'h8000_0000;
                    value_pool[1] = 32'h7FFF_FFFF;
                end
                case (mix)
                    MIX_FILL: begin
                        ins_share  = 65;
                        find_share = 20;
                    end
                    MIX_DRAIN: begin
                        ins_share  = 20;
                        find_share = 20;
                    end
                    default: begin
                        ins_share  = 40;
                        find_share = 30;
                    end
                endcase
            end
            roll  = $urandom_range(0, 99);
            value = pick_value();
            index = pick_index();
            if (mix == MIX_NOISE) begin
                cmd   = bsl_pkg::CMD_W'($urandom_range(0, 3));
                value = $urandom;
                index = bsl_pkg::INDEX_W'($urandom_range(0, 15));
            end else if (roll < ins_share) begin
                cmd = roll[0] ? bsl_pkg::CMD_INS_FRONT : bsl_pkg::CMD_INS_REAR;
            end else if (roll < ins_share + find_share) begin
                cmd = bsl_pkg::CMD_FIND;
            end else begin
                cmd = bsl_pkg::CMD_REMOVE;
            end
            send_command(cmd, value, index);
        end
        s_tvalid <= 1'b0;

        // drain: wait for every outstanding result, then a few list walks more
        do @(posedge aclk); while (pending != 0);
        repeat (2 * bsl_pkg::DEPTH_DEF + 8) @(posedge aclk);

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: bounded_sequence_list.f
rtl/bsl_pkg.sv
rtl/bsl_ram.sv
rtl/bounded_sequence_list.sv
tb/sv/bsl_result_checker.sv
tb/sv/tb_bounded_sequence_list.sv
